[hw/rtl/fgnh_pkg.sv]
// shared types and constants for the fractal gradient noise height block
// no dependencies; imported by the other files of the block except the checker
package fgnh_pkg;

    localparam int unsigned GridSideDefault = 512;
    localparam int unsigned TableSize       = 256;
    localparam int unsigned TableAw         = 8;
    localparam int unsigned HashW           = 3;
    localparam int unsigned CellW           = 9;
    localparam int unsigned HeightW         = 24;
    localparam int unsigned CfgAw           = 3;
    localparam int unsigned CfgDw           = 24;

    // input mode codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_CELL = 1'b1;

    // configuration register indexes
    typedef enum logic [CfgAw-1:0] {
        CFG_FREQ  = 3'd0,
        CFG_OCT   = 3'd1,
        CFG_PERS  = 3'd2,
        CFG_FLOOR = 3'd3,
        CFG_CEIL  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        freq;
        logic [3:0]         oct;
        logic [15:0]        pers;
        logic signed [23:0] floor_h;
        logic signed [23:0] ceil_h;
    } t_cfg;

    // one classified word handed from the front end to the back end
    typedef struct packed {
        logic               is_cell;
        logic [TableAw-1:0] idx;
        logic [HashW-1:0]   val;
        logic [CellW-1:0]   x;
        logic [CellW-1:0]   z;
    } t_job;

endpackage

[hw/rtl/fgnh_front.sv]
// front end: accepts input words, classifies them and queues them as jobs
// depends on fgnh_pkg
module fgnh_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_mode,
    input  logic [7:0]           i_table_index,
    input  logic [7:0]           i_table_value,
    input  logic [8:0]           i_cell_x,
    input  logic [8:0]           i_cell_z,
    output logic                 o_job_valid,
    input  logic                 i_job_ready,
    output fgnh_pkg::t_job       o_job
);
    import fgnh_pkg::*;

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_in;
    logic       w_out;
    t_job       w_job;

    assign o_full      = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_slot[r_rp];
    assign w_in        = i_push && !o_full;
    assign w_out       = o_job_valid && i_job_ready;

    always_comb begin
        w_job.is_cell = (i_mode == MODE_CELL);
        w_job.idx     = i_table_index;
        w_job.val     = i_table_value[HashW-1:0];  // gradient only needs the low bits
        w_job.x       = i_cell_x;
        w_job.z       = i_cell_z;
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_slot[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_wp <= ~r_wp;
            end
            if (w_out) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end

endmodule

[hw/rtl/fgnh_back.sv]
// back end: hash table, octave sequencer, normalizing divider and height scaling
// depends on fgnh_pkg
module fgnh_back #(
    parameter int unsigned GRID_SIDE = fgnh_pkg::GridSideDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  fgnh_pkg::t_job     i_job,
    input  fgnh_pkg::t_cfg     i_cfg,
    output logic               o_res_push,
    input  logic               i_res_full,
    output logic signed [23:0] o_res_height
);
    import fgnh_pkg::*;

    localparam int unsigned RemW      = $clog2(GRID_SIDE);
    localparam int unsigned PosW      = CellW + 16;
    localparam int unsigned FracW     = RemW + 15;
    localparam int unsigned QuoSh     = PosW + RemW;
    localparam int unsigned FracSh    = FracW + RemW;
    localparam int unsigned NormSteps = 40;

    // rounded-up reciprocals of the grid side, exact for every dividend of their width
    localparam logic [PosW:0]  RecipQ =
        (PosW+1)'(((64'd1 << QuoSh) + 64'(GRID_SIDE) - 64'd1) / 64'(GRID_SIDE));
    localparam logic [FracW:0] RecipF =
        (FracW+1)'(((64'd1 << FracSh) + 64'(GRID_SIDE) - 64'd1) / 64'(GRID_SIDE));

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_PROD  = 15'b000000000000010,
        S_QUO   = 15'b000000000000100,
        S_REM   = 15'b000000000001000,
        S_COORD = 15'b000000000010000,
        S_RDA   = 15'b000000000100000,
        S_RDB   = 15'b000000001000000,
        S_RDC   = 15'b000000010000000,
        S_LERP1 = 15'b000000100000000,
        S_LERP2 = 15'b000001000000000,
        S_ACC   = 15'b000010000000000,
        S_NSET  = 15'b000100000000000,
        S_NDIV  = 15'b001000000000000,
        S_SCALE = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } t_state;

    function automatic logic signed [19:0] grad(input logic [2:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y);
        logic signed [19:0] u;
        logic signed [19:0] v;
        logic signed [19:0] r;
        u = h[2] ? 20'(y) : 20'(x);
        v = h[2] ? 20'(x) : 20'(y);
        r = h[0] ? -u : u;
        r = h[1] ? (r - (v <<< 1)) : (r + (v <<< 1));
        return r;
    endfunction

    t_state r_state;
    t_state n_state;

    logic [HashW-1:0]   r_mem [TableSize];
    logic [HashW-1:0]   r_rd0;
    logic [HashW-1:0]   r_rd1;
    logic [TableAw-1:0] w_a0;
    logic [TableAw-1:0] w_a1;

    logic [CellW-1:0]   r_cx;
    logic [CellW-1:0]   r_cz;
    logic [2:0]         r_oct_last;
    logic [2:0]         r_oi;
    logic [5:0]         r_cnt;

    logic [PosW-1:0]    r_dx;
    logic [PosW-1:0]    r_dz;
    logic [PosW-1:0]    r_quox;
    logic [PosW-1:0]    r_quoz;
    logic [FracW-1:0]   r_fdx;
    logic [FracW-1:0]   r_fdz;
    logic [23:0]        r_qsx;
    logic [23:0]        r_qsz;
    logic [23:0]        r_qx;
    logic [23:0]        r_qz;

    logic [31:0]        r_sqx;
    logic [31:0]        r_sqz;
    logic [31:0]        r_t3x;
    logic [31:0]        r_t3z;
    logic [19:0]        r_polyx;
    logic [19:0]        r_polyz;
    logic [16:0]        r_fx;
    logic [16:0]        r_fz;
    logic [HashW-1:0]   r_hx0;
    logic [HashW-1:0]   r_hz0;

    logic signed [19:0] r_gaa;
    logic signed [19:0] r_gab;
    logic signed [19:0] r_gba;
    logic signed [19:0] r_gbb;
    logic signed [20:0] r_r1;
    logic signed [20:0] r_r2;
    logic signed [20:0] r_noise;
    logic signed [23:0] r_sum;
    logic [19:0]        r_tot;
    logic [16:0]        r_amp;

    logic               r_nneg;
    logic [39:0]        r_nd;
    logic [19:0]        r_nrem;
    logic [23:0]        r_nq;
    logic signed [42:0] r_prod;

    // grid position split into quotient and remainder of the grid side,
    // remainder fraction doubled once per octave
    logic [2*PosW:0]    w_mqx;
    logic [2*PosW:0]    w_mqz;
    logic [PosW-1:0]    w_qgx;
    logic [PosW-1:0]    w_qgz;
    logic [2*FracW:0]   w_mfx;
    logic [2*FracW:0]   w_mfz;
    logic [15:0]        w_xf;
    logic [15:0]        w_zf;
    logic [39:0]        w_polyfx;
    logic [39:0]        w_polyfz;
    logic signed [17:0] w_x0;
    logic signed [17:0] w_x1;
    logic signed [17:0] w_z0;
    logic signed [17:0] w_z1;
    logic [2:0]         w_haa;
    logic [2:0]         w_hab;
    logic [2:0]         w_hba;
    logic [2:0]         w_hbb;
    logic signed [20:0] w_d1;
    logic signed [20:0] w_d2;
    logic signed [38:0] w_p1;
    logic signed [38:0] w_p2;
    logic signed [21:0] w_d3;
    logic signed [39:0] w_p3;
    logic signed [38:0] w_pa;
    logic [20:0]        w_trn;
    logic               w_gen;
    logic [23:0]        w_abs;
    logic signed [25:0] w_q;
    logic signed [25:0] w_norm;
    logic signed [25:0] w_half;
    logic [16:0]        w_val;
    logic signed [24:0] w_span;
    logic [2:0]         w_last;

    assign o_job_ready  = (r_state == S_IDLE);
    assign o_res_push   = (r_state == S_OUT) && !i_res_full;
    assign o_res_height = i_cfg.floor_h + 24'(r_prod >>> 16);

    assign w_mqx = (2*PosW+1)'(r_dx) * (2*PosW+1)'(RecipQ);
    assign w_mqz = (2*PosW+1)'(r_dz) * (2*PosW+1)'(RecipQ);
    assign w_qgx = r_quox * PosW'(GRID_SIDE);
    assign w_qgz = r_quoz * PosW'(GRID_SIDE);
    assign w_mfx = (2*FracW+1)'(r_fdx) * (2*FracW+1)'(RecipF);
    assign w_mfz = (2*FracW+1)'(r_fdz) * (2*FracW+1)'(RecipF);
    assign w_xf  = r_qx[15:0];
    assign w_zf  = r_qz[15:0];

    // second lattice corner wraps around the table
    assign w_a0 = (r_state == S_RDB) ? (r_qx[23:16] + 8'd1) : r_qx[23:16];
    assign w_a1 = (r_state == S_RDB) ? (r_qz[23:16] + 8'd1) : r_qz[23:16];

    // quintic fade polynomial 6t^2 - 15t + 10, scaled back to q.16
    assign w_polyfx = 40'(r_sqx) * 40'd6 + (40'd10 << 32) - ((40'(w_xf) * 40'd15) << 16);
    assign w_polyfz = 40'(r_sqz) * 40'd6 + (40'd10 << 32) - ((40'(w_zf) * 40'd15) << 16);

    assign w_x0  = $signed({2'b00, w_xf});
    assign w_x1  = w_x0 - 18'sd65536;
    assign w_z0  = $signed({2'b00, w_zf});
    assign w_z1  = w_z0 - 18'sd65536;
    assign w_haa = r_hx0 + r_hz0;
    assign w_hab = r_hx0 + r_rd1;
    assign w_hba = r_rd0 + r_hz0;
    assign w_hbb = r_rd0 + r_rd1;

    assign w_d1 = 21'(r_gba) - 21'(r_gaa);
    assign w_d2 = 21'(r_gbb) - 21'(r_gab);
    assign w_p1 = $signed({1'b0, r_fx}) * w_d1;
    assign w_p2 = $signed({1'b0, r_fx}) * w_d2;
    assign w_d3 = 22'(r_r2) - 22'(r_r1);
    assign w_p3 = $signed({1'b0, r_fz}) * w_d3;
    assign w_pa = r_noise * $signed({1'b0, r_amp});

    assign w_trn = {r_nrem, r_nd[39]};
    assign w_gen = (w_trn >= {1'b0, r_tot});
    assign w_abs = r_sum[23] ? 24'(-r_sum) : 24'(r_sum);

    // floor division: a negative quotient with a remainder steps down by one
    assign w_q    = $signed({2'b00, r_nq});
    assign w_norm = r_nneg ? (-w_q - $signed(26'(r_nrem != '0))) : w_q;
    assign w_half = (w_norm + 26'sd65536) >>> 1;
    assign w_span = 25'(i_cfg.ceil_h) - 25'(i_cfg.floor_h);

    always_comb begin
        if (w_half < 26'sd0) begin
            w_val = 17'd0;
        end else if (w_half > 26'sd65536) begin
            w_val = 17'd65536;
        end else begin
            w_val = w_half[16:0];
        end
    end

    always_comb begin
        if (i_cfg.oct == 4'd0) begin
            w_last = 3'd0;
        end else if (i_cfg.oct > 4'd8) begin
            w_last = 3'd7;
        end else begin
            w_last = 3'(i_cfg.oct - 4'd1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid && i_job.is_cell) begin
                    n_state = S_PROD;
                end
            end
            S_PROD:  n_state = S_QUO;
            S_QUO:   n_state = S_REM;
            S_REM:   n_state = S_COORD;
            S_COORD: n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_RDC;
            S_RDC:   n_state = S_LERP1;
            S_LERP1: n_state = S_LERP2;
            S_LERP2: n_state = S_ACC;
            S_ACC: begin
                n_state = (r_oi == r_oct_last) ? S_NSET : S_COORD;
            end
            S_NSET:  n_state = S_NDIV;
            S_NDIV: begin
                if (r_cnt == 6'd1) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_OUT;
            S_OUT: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hash table: written by load words, two read ports for the lattice corners
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_job_valid && !i_job.is_cell) begin
            r_mem[i_job.idx] <= i_job.val;
        end
        r_rd0 <= r_mem[w_a0];
        r_rd1 <= r_mem[w_a1];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cx       <= i_job.x;
                r_cz       <= i_job.z;
                r_oct_last <= w_last;
            end
            S_PROD: begin
                r_dx    <= PosW'(r_cx) * PosW'(i_cfg.freq);
                r_dz    <= PosW'(r_cz) * PosW'(i_cfg.freq);
                r_amp   <= 17'd65536;
                r_sum   <= '0;
                r_tot   <= '0;
                r_oi    <= '0;
            end
            S_QUO: begin
                r_quox <= PosW'(w_mqx >> QuoSh);
                r_quoz <= PosW'(w_mqz >> QuoSh);
            end
            S_REM: begin
                r_fdx <= FracW'(r_dx - w_qgx) << 8;
                r_fdz <= FracW'(r_dz - w_qgz) << 8;
                r_qsx <= {r_quox[15:0], 8'h00};
                r_qsz <= {r_quoz[15:0], 8'h00};
            end
            S_COORD: begin
                r_qx <= r_qsx + 24'(w_mfx >> FracSh);
                r_qz <= r_qsz + 24'(w_mfz >> FracSh);
            end
            S_RDA: begin
                r_sqx <= 32'(w_xf) * 32'(w_xf);
                r_sqz <= 32'(w_zf) * 32'(w_zf);
            end
            S_RDB: begin
                r_hx0   <= r_rd0;
                r_hz0   <= r_rd1;
                r_t3x   <= 32'(r_sqx[31:16]) * 32'(w_xf);
                r_t3z   <= 32'(r_sqz[31:16]) * 32'(w_zf);
                r_polyx <= w_polyfx[35:16];
                r_polyz <= w_polyfz[35:16];
            end
            S_RDC: begin
                r_fx  <= 17'((36'(r_t3x[31:16]) * 36'(r_polyx)) >> 16);
                r_fz  <= 17'((36'(r_t3z[31:16]) * 36'(r_polyz)) >> 16);
                r_gaa <= grad(w_haa, w_x0, w_z0);
                r_gba <= grad(w_hba, w_x1, w_z0);
                r_gab <= grad(w_hab, w_x0, w_z1);
                r_gbb <= grad(w_hbb, w_x1, w_z1);
            end
            S_LERP1: begin
                r_r1 <= 21'(r_gaa) + 21'(w_p1 >>> 16);
                r_r2 <= 21'(r_gab) + 21'(w_p2 >>> 16);
            end
            S_LERP2: begin
                r_noise <= r_r1 + 21'(w_p3 >>> 16);
            end
            S_ACC: begin
                r_sum <= r_sum + 24'(w_pa >>> 16);
                r_tot <= r_tot + 20'(r_amp);
                r_amp <= 17'((33'(r_amp) * 33'(i_cfg.pers)) >> 16);
                r_oi  <= r_oi + 3'd1;
                // next octave doubles the position
                r_fdx <= r_fdx << 1;
                r_fdz <= r_fdz << 1;
                r_qsx <= r_qsx << 1;
                r_qsz <= r_qsz << 1;
            end
            S_NSET: begin
                r_nneg <= r_sum[23];
                r_nd   <= {w_abs, 16'h0000};
                r_nrem <= '0;
                r_nq   <= '0;
                r_cnt  <= 6'(NormSteps);
            end
            S_NDIV: begin
                r_nd   <= r_nd << 1;
                r_nrem <= w_gen ? 20'(w_trn - {1'b0, r_tot}) : 20'(w_trn);
                r_nq   <= {r_nq[22:0], w_gen};
                r_cnt  <= r_cnt - 6'd1;
            end
            S_SCALE: begin
                r_prod <= $signed({1'b0, w_val}) * w_span;
            end
            S_OUT: begin
                r_cnt <= r_cnt;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

[hw/rtl/fgnh_out_fifo.sv]
// two-entry result queue between the back end and the result port
// depends on fgnh_pkg
module fgnh_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic signed [23:0] i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output logic signed [23:0] o_data
);
    import fgnh_pkg::*;

    logic signed [HeightW-1:0] r_slot [2];
    logic                      r_wp;
    logic                      r_rp;
    logic [1:0]                r_cnt;
    logic                      w_in;
    logic                      w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_slot[r_rp];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_wp <= ~r_wp;
            end
            if (w_out) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end

endmodule

[hw/rtl/fractal_gradient_noise_height.sv]
// top level of the fractal gradient noise height block
// depends on fgnh_pkg, fgnh_front, fgnh_back, fgnh_out_fifo
//
// usage:
//   input words go in on i_push/o_full. mode 0 writes one 3-bit hash table
//   entry and gives no result; mode 1 gives one height word for cell (x, z).
//   results come out on o_empty/i_pop, oldest first, held until popped.
//   configuration is written on i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// sequencing:
//   a load word passes through the input queue and is written into the table
//   when the back end is idle.
//   a cell result passes through the product, quotient and remainder states that
//   split the grid position by reciprocal multiplies, the coordinate, table read,
//   gradient, blend and accumulate states of each octave on the shared noise unit,
//   a 40-step serial divide to normalize and the scale and output states that hand
//   it over. the back end works on one word at a time, so a new cell is taken only
//   after the last result is handed over. the hash table has one write port and
//   two read ports; the entries of the four corners are read two at a time per octave.
// reset clears the queues and the sequencer and loads the register defaults;
// hash table entries read before being written give undefined heights.
// when the receiver stalls, two results wait in the output queue, the back
// end holds the third, and two more words wait in the input queue.
module fractal_gradient_noise_height #(
    parameter int unsigned GRID_SIDE = fgnh_pkg::GridSideDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_mode,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_table_value,
    input  logic [8:0]         i_cell_x,
    input  logic [8:0]         i_cell_z,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [23:0] o_height,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data
);
    import fgnh_pkg::*;

    t_cfg               r_cfg;
    t_job               w_job;
    logic               w_job_valid;
    logic               w_job_ready;
    logic               w_res_push;
    logic               w_res_full;
    logic signed [23:0] w_res_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq    <= 16'd1024;
            r_cfg.oct     <= 4'd6;
            r_cfg.pers    <= 16'd32768;
            r_cfg.floor_h <= 24'sd0;
            r_cfg.ceil_h  <= 24'sd25600;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FREQ:  r_cfg.freq    <= i_cfg_data[15:0];
                CFG_OCT:   r_cfg.oct     <= i_cfg_data[3:0];
                CFG_PERS:  r_cfg.pers    <= i_cfg_data[15:0];
                CFG_FLOOR: r_cfg.floor_h <= $signed(i_cfg_data);
                CFG_CEIL:  r_cfg.ceil_h  <= $signed(i_cfg_data);
                default:   r_cfg         <= r_cfg;  // unknown index is dropped
            endcase
        end
    end

    fgnh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_mode        (i_mode),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_cell_x      (i_cell_x),
        .i_cell_z      (i_cell_z),
        .o_job_valid   (w_job_valid),
        .i_job_ready   (w_job_ready),
        .o_job         (w_job)
    );

    fgnh_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_job_valid),
        .o_job_ready  (w_job_ready),
        .i_job        (w_job),
        .i_cfg        (r_cfg),
        .o_res_push   (w_res_push),
        .i_res_full   (w_res_full),
        .o_res_height (w_res_height)
    );

    fgnh_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_height),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_height)
    );

endmodule

[hw/rtl/fgnh_checker.sv]
// port-level checks for the fractal gradient noise height block
// depends on fractal_gradient_noise_height; attached by the bind below
module fgnh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_push,
    input logic               o_full,
    input logic               i_pop,
    input logic               o_empty,
    input logic signed [23:0] o_height
);

    // queues come out of reset empty
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("input queue full after reset");

    // the input queue only fills because of an accepted word
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_full) |-> $past(i_push))
        else $error("input queue filled without a push");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_height)))
        else $error("waiting result changed");

endmodule

bind fractal_gradient_noise_height fgnh_checker u_fgnh_checker (.*);

[verif/tb_top.sv]
// self-checking testbench for fractal_gradient_noise_height
// depends on fgnh_pkg and the block's rtl; carries its own bit-exact height predictor
module tb_top;
    import fgnh_pkg::*;

    localparam int unsigned GridSide = 512;
    localparam logic [2:0] CFG_NONE = 3'd7;   // index past the register list

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push = 1'b0;
    logic               o_full;
    logic               i_mode = MODE_LOAD;
    logic [7:0]         i_table_index = '0;
    logic [7:0]         i_table_value = '0;
    logic [8:0]         i_cell_x = '0;
    logic [8:0]         i_cell_z = '0;
    logic               o_empty;
    logic               i_pop = 1'b0;
    logic signed [23:0] o_height;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [23:0]        i_cfg_data = '0;

    fractal_gradient_noise_height #(.GRID_SIDE(GridSide)) i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [2:0]  hash_mem [TableSize];
    logic [15:0] freq_r = 16'd1024;
    logic [3:0]  oct_r = 4'd6;
    logic [15:0] pers_r = 16'd32768;
    logic [23:0] floor_r = 24'd0;
    logic [23:0] ceil_r = 24'd25600;

    logic signed [23:0] height_due_q [$];
    int err_cnt = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int stall_left = 0;

    typedef struct {
        bit                 is_cfg;
        logic [2:0]         cidx;
        logic [23:0]        cdata;
        logic               mode;
        logic [7:0]         ti;
        logic [7:0]         tv;
        logic [8:0]         x;
        logic [8:0]         z;
        bit                 has_exp;
        logic signed [23:0] exp_h;
    } t_row;
    t_row rows [$];

    function automatic longint fl_shr16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint fl_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint fade(longint t);
        longint poly, t2, t3;
        poly = (6 * t * t - 15 * t * 65536 + 10 * (64'sd1 <<< 32)) >>> 16;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        return (t3 * poly) >>> 16;
    endfunction

    function automatic longint grad(logic [2:0] h, longint x, longint y);
        longint u, v, r;
        u = (h < 3'd4) ? x : y;
        v = (h < 3'd4) ? y : x;
        r = h[0] ? -u : u;
        r += h[1] ? -2 * v : 2 * v;
        return r;
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + fl_shr16(t * (b - a));
    endfunction

    function automatic longint noise(longint cx, longint cz);
        logic [7:0] xi, zi, xn, zn;
        longint xf, zf, u, v, r1, r2;
        xi = cx[23:16];
        zi = cz[23:16];
        xn = xi + 8'd1;   // 255 wraps to entry 0
        zn = zi + 8'd1;
        xf = cx & 64'hFFFF;
        zf = cz & 64'hFFFF;
        u = fade(xf);
        v = fade(zf);
        r1 = blend(grad(hash_mem[xi] + hash_mem[zi], xf, zf),
                   grad(hash_mem[xn] + hash_mem[zi], xf - 65536, zf), u);
        r2 = blend(grad(hash_mem[xi] + hash_mem[zn], xf, zf - 65536),
                   grad(hash_mem[xn] + hash_mem[zn], xf - 65536, zf - 65536), u);
        return blend(r1, r2, v);
    endfunction

    function automatic logic signed [23:0] calc_height(logic [8:0] x, logic [8:0] z);
        int unsigned n_oct;
        longint amp, amp_sum, acc, px, pz, norm, val, lo, span;
        amp = 65536;
        amp_sum = 0;
        acc = 0;
        n_oct = (oct_r < 1) ? 1 : (oct_r > 8) ? 8 : oct_r;
        px = longint'(x) * freq_r;
        pz = longint'(z) * freq_r;
        for (int o = 0; o < n_oct; o++) begin
            acc += fl_shr16(noise((px << (8 + o)) / GridSide, (pz << (8 + o)) / GridSide) * amp);
            amp_sum += amp;
            amp = (amp * longint'(pers_r)) >>> 16;
        end
        norm = fl_div(acc * 65536, amp_sum);
        val = fl_div(norm + 65536, 2);
        if (val < 0) val = 0;
        if (val > 65536) val = 65536;
        lo = longint'(signed'(floor_r));
        span = longint'(signed'(ceil_r)) - lo;
        return 24'(lo + fl_shr16(val * span));
    endfunction

    task automatic report(string what, logic signed [23:0] got, logic signed [23:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    // one input word, prediction taken at acceptance
    task automatic send_word(logic mode, logic [7:0] ti, logic [7:0] tv,
                             logic [8:0] x, logic [8:0] z, bit has_exp,
                             logic signed [23:0] exp_h);
        while ($urandom_range(99) < send_idle) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_mode <= mode;
        i_table_index <= ti;
        i_table_value <= tv;
        i_cell_x <= x;
        i_cell_z <= z;
        do @(posedge i_clk); while (o_full);
        if (mode == MODE_LOAD) hash_mem[ti] = tv[2:0];
        else height_due_q = {height_due_q, (has_exp ? exp_h : calc_height(x, z))};
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        while (height_due_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);   // load words leave no result behind
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FREQ:  freq_r = data[15:0];
            CFG_OCT:   oct_r = data[3:0];
            CFG_PERS:  pers_r = data[15:0];
            CFG_FLOOR: floor_r = data;
            CFG_CEIL:  ceil_r = data;
            default: ;
        endcase
    endtask

    function automatic void add_cell(logic [8:0] x, logic [8:0] z, bit has = 0,
                                     logic signed [23:0] e = 0);
        t_row r;
        r = '{default: '0};
        r.mode = MODE_CELL;
        r.x = x;
        r.z = z;
        r.has_exp = has;
        r.exp_h = e;
        rows = {rows, r};
    endfunction

    function automatic void add_load(logic [7:0] ti, logic [7:0] tv);
        t_row r;
        r = '{default: '0};
        r.mode = MODE_LOAD;
        r.ti = ti;
        r.tv = tv;
        rows = {rows, r};
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [23:0] data);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1;
        r.cidx = idx;
        r.cdata = data;
        rows = {rows, r};
    endfunction

    // receiver with random idling and a long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (stall_left > 0) begin
                stall_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(99) >= recv_idle);
            end
            @(posedge i_clk);
            if (i_pop && !o_empty) begin
                if (height_due_q.size() == 0) report("unexpected word", o_height, 0);
                else if (o_height !== height_due_q[0])
                    report("height", o_height, height_due_q.pop_front());
                else void'(height_due_q.pop_front());
            end
        end
    end

    initial begin
        #(12 * 4000000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [23:0] lo_h, hi_h;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table so no entry is read unwritten
        for (int i = 0; i < TableSize; i++)
            send_word(MODE_LOAD, 8'(i), 8'($urandom_range(254)), '0, '0, 0, 0);

        // directed part
        add_cell(0, 0, 1, 24'sd12800);          // reset defaults, zero coordinates
        add_cell(511, 511);
        add_cell(255, 256);
        add_load(255, 254);
        add_load(0, 0);
        add_cell(511, 0);                        // largest x coordinate
        add_cell(0, 511);
        add_cfg(CFG_FREQ, 0);                    // zero frequency gives the midpoint
        add_cell(511, 511, 1, 24'sd12800);
        add_cell(123, 45, 1, 24'sd12800);
        add_cfg(CFG_FREQ, 16'hFFFF);
        add_cfg(CFG_OCT, 0);                     // taken as one octave
        add_cell(511, 511);
        add_cell(1, 1);
        add_cfg(CFG_OCT, 15);                    // saturates to eight
        add_cell(300, 77);
        add_cfg(CFG_PERS, 16'hFFFF);
        add_cell(511, 3);
        add_cfg(CFG_PERS, 0);
        add_cell(17, 400);
        add_cfg(CFG_FLOOR, 24'h7FFFFF);
        add_cfg(CFG_CEIL, 24'h7FFFFF);
        add_cell(200, 200, 1, 24'sh7FFFFF);
        add_cfg(CFG_CEIL, 24'h800000);           // floor above ceiling
        add_cell(0, 0, 1, -24'sd1);
        add_cell(511, 250);
        add_cfg(CFG_NONE, 24'h123456);           // ignored write
        add_cell(5, 9);
        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_reg(rows[i].cidx, rows[i].cdata);
            else send_word(rows[i].mode, rows[i].ti, rows[i].tv, rows[i].x, rows[i].z,
                           rows[i].has_exp, rows[i].exp_h);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            send_idle = (ph < 3) ? 6 : (ph < 6) ? 51 : 0;
            recv_idle = (ph < 3) ? 51 : (ph < 6) ? 6 : 0;
            case ($urandom_range(3))
                0: write_reg(CFG_FREQ, 24'($urandom_range(1, 2048)));
                1: write_reg(CFG_FREQ, 24'($urandom_range(1, 65535)));
                2: write_reg(CFG_FREQ, 24'd1);
                default: write_reg(CFG_FREQ, 24'hFFFF);
            endcase
            write_reg(CFG_OCT, 24'(ph == 7 ? 8 : $urandom_range(15)));
            write_reg(CFG_PERS, 24'($urandom_range(65535)));
            lo_h = 24'($urandom);
            hi_h = (ph % 2) ? 24'($urandom) : lo_h + 24'($urandom_range(65535));
            write_reg(CFG_FLOOR, lo_h);
            write_reg(CFG_CEIL, hi_h);
            if (ph == 0 || ph == 6) stall_left = 400;   // fill the block and stall its input
            for (int n = 0; n < 65; n++) begin
                if ($urandom_range(99) < 70)
                    send_word(MODE_CELL, 8'($urandom), 8'($urandom),
                              9'($urandom), 9'($urandom), 0, 0);
                else
                    send_word(MODE_LOAD, 8'($urandom), 8'($urandom_range(254)),
                              9'($urandom), 9'($urandom), 0, 0);
            end
        end

        i_push <= 1'b0;
        while (height_due_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0 && height_due_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
